[rtl/btpm_pkg.sv]
// Shared types, constants and pattern table for the binary tile pattern mask.
// No dependencies; every other file refers to it by scoped names.
package btpm_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int MODE_W     = 3;
    localparam int THR_W      = 8;
    localparam int DIM_W      = 13;
    localparam int PIXEL_W    = 8;
    localparam int POS_W      = 12;
    localparam int SIZE_W     = 2;
    localparam int MASK_W     = 9;
    localparam int ENTRY_W    = 2;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRAY_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 2'd3;

    localparam logic [MODE_W-1:0] RST_PATTERN_MODE   = 3'd0;
    localparam logic [THR_W-1:0]  RST_GRAY_THRESHOLD = 8'd127;
    localparam logic [DIM_W-1:0]  RST_FRAME_WIDTH    = 13'd640;
    localparam logic [DIM_W-1:0]  RST_FRAME_HEIGHT   = 13'd480;

    localparam logic [MODE_W-1:0] MODE_PASS       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DIAG_2X2   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ELL_2X2    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FULL_2X2   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CORNER_3X3 = 3'd4;
    localparam logic [MODE_W-1:0] MODE_WEDGE_3X3  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_CROSS_3X3  = 3'd6;
    localparam logic [MODE_W-1:0] MODE_FIRST_3X3  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_UNION      = 3'd7;

    localparam logic [MASK_W-1:0] UNION_TOP_ROW  = 9'h007;
    localparam logic [MASK_W-1:0] UNION_LEFT_COL = 9'h049;

    // per-pixel control word handed from the position stage to the tile stage
    typedef struct packed {
        logic              bit_set;
        logic [MODE_W-1:0] mode;
        logic              size3;
        logic              in_tile;
        logic              last_row;
        logic              last_col;
        logic [1:0]        rr;
        logic [1:0]        cc;
    } pixel_info_t;

    function automatic logic [MASK_W-1:0] tile_pattern(input logic [MODE_W-1:0] mode);
        logic [MASK_W-1:0] p;
        begin
            case (mode)
                MODE_DIAG_2X2:   p = 9'h009;
                MODE_ELL_2X2:    p = 9'h00D;
                MODE_FULL_2X2:   p = 9'h00F;
                MODE_CORNER_3X3: p = 9'h04F;
                MODE_WEDGE_3X3:  p = 9'h05F;
                MODE_CROSS_3X3:  p = 9'h155;
                default:         p = 9'h000;
            endcase
            return p;
        end
    endfunction

    function automatic logic [MASK_W-1:0] judge_tile(input logic [MODE_W-1:0] mode,
                                                     input logic [MASK_W-1:0] bits);
        logic [MASK_W-1:0] m;
        logic [MASK_W-1:0] p;
        begin
            m = '0;
            p = tile_pattern(mode);
            if (mode == MODE_UNION)
            begin
                if ((bits & UNION_TOP_ROW) == UNION_TOP_ROW)
                    m = m | UNION_TOP_ROW;
                if ((bits & UNION_LEFT_COL) == UNION_LEFT_COL)
                    m = m | UNION_LEFT_COL;
            end
            else if ((bits & p) == p)
            begin
                m = p;
            end
            return m;
        end
    endfunction

endpackage

[rtl/btpm_line_mem.sv]
// Band line store: one 2-bit entry per column, synchronous read into a register.
// Forwards a same-cycle write to the same entry. Uses btpm_pkg.
module btpm_line_mem #(
    parameter int DEPTH = btpm_pkg::DEF_MAX_WIDTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [btpm_pkg::ENTRY_W-1:0] wr_data,
    output logic [btpm_pkg::ENTRY_W-1:0] rd_data
);

    logic [btpm_pkg::ENTRY_W-1:0] ram [DEPTH];
    logic [btpm_pkg::ENTRY_W-1:0] ram_q_reg;
    logic [btpm_pkg::ENTRY_W-1:0] byp_data_reg;
    logic                         byp_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            ram[wr_addr] <= wr_data;
        if (rd_en)
        begin
            ram_q_reg    <= ram[rd_addr];
            byp_data_reg <= wr_data;
        end
    end

    // entry being written as it is read: take the new word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byp_hit_reg <= 1'b0;
        else if (rd_en)
            byp_hit_reg <= wr_en && (wr_addr == rd_addr);
    end

    assign rd_data = byp_hit_reg ? byp_data_reg : ram_q_reg;

endmodule

[rtl/btpm_pos_ctrl.sv]
// Raster position tracking: column/row counters with mod-3 companions, tile placement
// and pixel thresholding. Uses btpm_pkg.
module btpm_pos_ctrl #(
    parameter int MAX_WIDTH  = btpm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = btpm_pkg::DEF_MAX_HEIGHT,
    parameter int CW = $clog2(MAX_WIDTH),
    parameter int RW = $clog2(MAX_HEIGHT)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             accept,
    input  logic [btpm_pkg::PIXEL_W-1:0]     gray_pixel,
    input  logic                             frame_start,
    input  logic [btpm_pkg::MODE_W-1:0]      mode,
    input  logic [btpm_pkg::THR_W-1:0]       threshold,
    input  logic [btpm_pkg::DIM_W-1:0]       frame_width,
    input  logic [btpm_pkg::DIM_W-1:0]       frame_height,
    output logic [CW-1:0]                    col,
    output logic [RW-1:0]                    row,
    output btpm_pkg::pixel_info_t            info
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int TW = WW + 1;
    localparam int UW = HW + 1;
    localparam int LW = btpm_pkg::DIM_W + 1;

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [1:0]    c3_reg, c3_next;
    logic [1:0]    r3_reg, r3_next;

    logic [WW-1:0] w;
    logic [HW-1:0] h;
    logic [1:0]    c3_cur, r3_cur;
    logic          size3;
    logic [1:0]    s, cc, rr;
    logic [WW-1:0] col_inc;
    logic [HW-1:0] row_inc;
    logic          col_fit, row_fit;

    // clamp dimensions to 1..MAX
    always_comb
    begin
        if (frame_width == '0)
            w = WW'(1);
        else if (LW'(frame_width) > LW'(MAX_WIDTH))
            w = WW'(MAX_WIDTH);
        else
            w = WW'(frame_width);
        if (frame_height == '0)
            h = HW'(1);
        else if (LW'(frame_height) > LW'(MAX_HEIGHT))
            h = HW'(MAX_HEIGHT);
        else
            h = HW'(frame_height);
    end

    always_comb
    begin
        col    = frame_start ? '0 : col_reg;
        row    = frame_start ? '0 : row_reg;
        c3_cur = frame_start ? 2'd0 : c3_reg;
        r3_cur = frame_start ? 2'd0 : r3_reg;
        size3  = (mode >= btpm_pkg::MODE_FIRST_3X3);
        s      = size3 ? 2'd3 : 2'd2;
        cc     = size3 ? c3_cur : {1'b0, col[0]};
        rr     = size3 ? r3_cur : {1'b0, row[0]};
        // tile holding this pixel ends inside the frame
        col_fit = (TW'(col) + TW'(s - cc)) <= TW'(w);
        row_fit = (UW'(row) + UW'(s - rr)) <= UW'(h);

        info.bit_set  = (gray_pixel > threshold);
        info.mode     = mode;
        info.size3    = size3;
        info.in_tile  = (mode != btpm_pkg::MODE_PASS) && col_fit && row_fit;
        info.last_row = (rr == s - 2'd1);
        info.last_col = (cc == s - 2'd1);
        info.rr       = rr;
        info.cc       = cc;
    end

    always_comb
    begin
        col_inc  = WW'(col) + WW'(1);
        row_inc  = HW'(row) + HW'(1);
        col_next = CW'(col_inc);
        row_next = row;
        c3_next  = (c3_cur == 2'd2) ? 2'd0 : c3_cur + 2'd1;
        r3_next  = r3_cur;
        if (col_inc >= w)
        begin
            col_next = '0;
            c3_next  = 2'd0;
            if (row_inc >= h)
            begin
                row_next = '0;
                r3_next  = 2'd0;
            end
            else
            begin
                row_next = RW'(row_inc);
                r3_next  = (r3_cur == 2'd2) ? 2'd0 : r3_cur + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            c3_reg  <= 2'd0;
            r3_reg  <= 2'd0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            c3_reg  <= c3_next;
            r3_reg  <= r3_next;
        end
    end

endmodule

[rtl/btpm_tile_eval.sv]
// Tile stage: takes the line-store read, writes the entry back, gathers the tile
// bits, judges the pattern and holds the result word. Uses btpm_pkg.
module btpm_tile_eval #(
    parameter int MAX_WIDTH  = btpm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = btpm_pkg::DEF_MAX_HEIGHT,
    parameter int CW = $clog2(MAX_WIDTH),
    parameter int RW = $clog2(MAX_HEIGHT)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             accept,
    input  btpm_pkg::pixel_info_t            info,
    input  logic [CW-1:0]                    col,
    input  logic [RW-1:0]                    row,
    input  logic [btpm_pkg::ENTRY_W-1:0]     rd_data,
    output logic                             wr_en,
    output logic [CW-1:0]                    wr_addr,
    output logic [btpm_pkg::ENTRY_W-1:0]     wr_data,
    output logic                             pixel_stall,
    output logic                             block_valid,
    input  logic                             block_stall,
    output logic [btpm_pkg::POS_W-1:0]       origin_row,
    output logic [btpm_pkg::POS_W-1:0]       origin_col,
    output logic [btpm_pkg::SIZE_W-1:0]      block_size,
    output logic [btpm_pkg::MASK_W-1:0]      mask_bits
);

    localparam int OCW = (CW > btpm_pkg::POS_W) ? CW : btpm_pkg::POS_W;
    localparam int ORW = (RW > btpm_pkg::POS_W) ? RW : btpm_pkg::POS_W;

    btpm_pkg::pixel_info_t           s1_info_reg;
    logic [CW-1:0]                   s1_col_reg;
    logic [RW-1:0]                   s1_row_reg;
    logic                            s1_valid_reg;
    logic [btpm_pkg::MASK_W-1:0]     recent_reg, recent_next;
    logic                            out_valid_reg;
    logic [btpm_pkg::POS_W-1:0]      out_row_reg, out_row_next;
    logic [btpm_pkg::POS_W-1:0]      out_col_reg, out_col_next;
    logic [btpm_pkg::SIZE_W-1:0]     out_size_reg, out_size_next;
    logic [btpm_pkg::MASK_W-1:0]     out_mask_reg, out_mask_next;

    logic                            s1_adv;
    logic                            emit;
    logic                            tile_row;
    logic [1:0]                      s_m1;
    logic [3:0]                      sh0, sh1, sh2;
    logic [btpm_pkg::MASK_W-1:0]     contrib;
    logic [CW-1:0]                   org_col;
    logic [RW-1:0]                   org_row;
    logic [OCW-1:0]                  org_col_ext;
    logic [ORW-1:0]                  org_row_ext;

    assign s1_adv      = s1_valid_reg && (!out_valid_reg || !block_stall);
    assign pixel_stall = s1_valid_reg && !s1_adv;
    assign tile_row    = s1_info_reg.in_tile && s1_info_reg.last_row;

    // read-modify-write of the band entry on the earlier rows of a tile
    always_comb
    begin
        wr_en   = s1_adv && s1_info_reg.in_tile && !s1_info_reg.last_row;
        wr_addr = s1_col_reg;
        wr_data = rd_data;
        wr_data[s1_info_reg.rr[0]] = s1_info_reg.bit_set;
    end

    always_comb
    begin
        s_m1 = s1_info_reg.size3 ? 2'd2 : 2'd1;
        sh0  = {2'b00, s1_info_reg.cc};
        sh1  = sh0 + (s1_info_reg.size3 ? 4'd3 : 4'd2);
        sh2  = sh0 + 4'd6;
        if (s1_info_reg.size3)
            contrib = (btpm_pkg::MASK_W'(rd_data[0]) << sh0)
                    | (btpm_pkg::MASK_W'(rd_data[1]) << sh1)
                    | (btpm_pkg::MASK_W'(s1_info_reg.bit_set) << sh2);
        else
            contrib = (btpm_pkg::MASK_W'(rd_data[0]) << sh0)
                    | (btpm_pkg::MASK_W'(s1_info_reg.bit_set) << sh1);
        recent_next = ((s1_info_reg.cc == 2'd0) ? '0 : recent_reg) | contrib;

        org_col     = s1_col_reg - CW'(s_m1);
        org_row     = s1_row_reg - RW'(s_m1);
        org_col_ext = OCW'(org_col);
        org_row_ext = ORW'(org_row);

        emit          = !s1_info_reg.in_tile || (tile_row && s1_info_reg.last_col);
        out_row_next  = btpm_pkg::POS_W'(ORW'(s1_row_reg));
        out_col_next  = btpm_pkg::POS_W'(OCW'(s1_col_reg));
        out_size_next = btpm_pkg::SIZE_W'(1);
        out_mask_next = btpm_pkg::MASK_W'(s1_info_reg.bit_set);
        if (s1_info_reg.in_tile)
        begin
            out_row_next  = org_row_ext[btpm_pkg::POS_W-1:0];
            out_col_next  = org_col_ext[btpm_pkg::POS_W-1:0];
            out_size_next = btpm_pkg::SIZE_W'(s_m1 + 2'd1);
            out_mask_next = btpm_pkg::judge_tile(s1_info_reg.mode, recent_next);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_info_reg <= info;
            s1_col_reg  <= col;
            s1_row_reg  <= row;
        end
        if (s1_adv && emit)
        begin
            out_row_reg  <= out_row_next;
            out_col_reg  <= out_col_next;
            out_size_reg <= out_size_next;
            out_mask_reg <= out_mask_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            recent_reg    <= '0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv)
                out_valid_reg <= emit;
            else if (!block_stall)
                out_valid_reg <= 1'b0;

            if (s1_adv && tile_row)
                recent_reg <= recent_next;
        end
    end

    assign block_valid = out_valid_reg;
    assign origin_row  = out_row_reg;
    assign origin_col  = out_col_reg;
    assign block_size  = out_size_reg;
    assign mask_bits   = out_mask_reg;

endmodule

[rtl/binary_tile_pattern_mask_core.sv]
// Top level of the binary tile pattern mask: configuration registers and the
// position stage, line store and tile stage. Uses btpm_pkg and the btpm_* modules.
//
// Pixel channel: gray_pixel and frame_start with pixel_valid/pixel_stall; a word
// is taken at a clock edge where pixel_valid is high and pixel_stall is low.
// Block channel: origin_row, origin_col, block_size, mask_bits with
// block_valid/block_stall; at most one block word per pixel word. A pixel inside
// a whole tile gives a word only when it is the tile's bottom-right pixel.
// Throughput is one pixel per cycle while the output word is not held by block_stall:
// each pixel does at most one read and at most one write of the band line store,
// a synchronous memory. The store is read at the edge that takes the pixel into the
// tile stage registers; the block word loads into the output register when that stage
// advances, and shows on the ports from then on. When block_stall is held, the output
// word stays put, one more pixel can be taken into the tile stage if it is empty, and
// once that stage holds a pixel, pixel_stall is high until the word moves on.
// Reset clears the position counters, the gathered tile bits and both stages and
// loads the register defaults; the line store is not cleared and needs no
// clearing pass. Registers are written through cfg_we/cfg_index/cfg_data; the user
// must write them only while the block is idle, which the block itself does not enforce.
module binary_tile_pattern_mask_core #(
    parameter int MAX_WIDTH  = btpm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = btpm_pkg::DEF_MAX_HEIGHT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [btpm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [btpm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             pixel_valid,
    output logic                             pixel_stall,
    input  logic [btpm_pkg::PIXEL_W-1:0]     gray_pixel,
    input  logic                             frame_start,
    output logic                             block_valid,
    input  logic                             block_stall,
    output logic [btpm_pkg::POS_W-1:0]       origin_row,
    output logic [btpm_pkg::POS_W-1:0]       origin_col,
    output logic [btpm_pkg::SIZE_W-1:0]      block_size,
    output logic [btpm_pkg::MASK_W-1:0]      mask_bits
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [btpm_pkg::MODE_W-1:0] mode_reg;
    logic [btpm_pkg::THR_W-1:0]  threshold_reg;
    logic [btpm_pkg::DIM_W-1:0]  width_reg;
    logic [btpm_pkg::DIM_W-1:0]  height_reg;

    logic                         accept;
    btpm_pkg::pixel_info_t        info;
    logic [CW-1:0]                col;
    logic [RW-1:0]                row;
    logic [btpm_pkg::ENTRY_W-1:0] rd_data;
    logic                         wr_en;
    logic [CW-1:0]                wr_addr;
    logic [btpm_pkg::ENTRY_W-1:0] wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= btpm_pkg::RST_PATTERN_MODE;
            threshold_reg <= btpm_pkg::RST_GRAY_THRESHOLD;
            width_reg     <= btpm_pkg::RST_FRAME_WIDTH;
            height_reg    <= btpm_pkg::RST_FRAME_HEIGHT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                btpm_pkg::REG_PATTERN_MODE:
                    mode_reg <= cfg_data[btpm_pkg::MODE_W-1:0];
                btpm_pkg::REG_GRAY_THRESHOLD:
                    threshold_reg <= cfg_data[btpm_pkg::THR_W-1:0];
                btpm_pkg::REG_FRAME_WIDTH:
                    width_reg <= cfg_data;
                btpm_pkg::REG_FRAME_HEIGHT:
                    height_reg <= cfg_data;
                default:
                    ;
            endcase
        end
    end

    assign accept = pixel_valid && !pixel_stall;

    btpm_pos_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CW         (CW),
        .RW         (RW)
    ) u_pos (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .gray_pixel   (gray_pixel),
        .frame_start  (frame_start),
        .mode         (mode_reg),
        .threshold    (threshold_reg),
        .frame_width  (width_reg),
        .frame_height (height_reg),
        .col          (col),
        .row          (row),
        .info         (info)
    );

    btpm_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept && info.in_tile),
        .rd_addr (col),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    btpm_tile_eval #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CW         (CW),
        .RW         (RW)
    ) u_eval (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .info        (info),
        .col         (col),
        .row         (row),
        .rd_data     (rd_data),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .pixel_stall (pixel_stall),
        .block_valid (block_valid),
        .block_stall (block_stall),
        .origin_row  (origin_row),
        .origin_col  (origin_col),
        .block_size  (block_size),
        .mask_bits   (mask_bits)
    );

endmodule
